// ----- rtl/u8dec_pkg.sv -----
// Shared types and constants of the UTF-8 to UCS-2 decoder.
// No dependencies; the front end, queue, back end and top level import this package.
`default_nettype none

package u8dec_pkg;

    // Byte queue between the classifier and the decoder back end
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] SPACE_UNIT = 16'h0020;

    // Lead byte masks and codes
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] LEAD5_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_CODE = 8'hF8;
    localparam logic [7:0] LEAD2_DATA = 8'h1F;
    localparam logic [7:0] LEAD3_DATA = 8'h0F;
    localparam logic [7:0] CONT_DATA  = 8'h3F;

    // Bytes dropped after an unsupported lead
    localparam logic [2:0] SKIP_LEAD4 = 3'd3;
    localparam logic [2:0] SKIP_LEAD5 = 3'd4;
    localparam logic [2:0] SKIP_OTHER = 3'd5;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_LEAD5,
        CLS_OTHER
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
        logic        last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic skip_active;
        logic pend_active;
    } back_stat_t;

endpackage

`default_nettype wire

// ----- rtl/u8dec_byte_if.sv -----
// Input channel of the decoder: one raw byte per item plus the end flag.
// No dependencies.
`default_nettype none

interface u8dec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/u8dec_unit_if.sv -----
// Output channel of the decoder: one 16-bit code unit per item with flags.
// No dependencies.
`default_nettype none

interface u8dec_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        has_unit;
    logic        end_of_string;

    modport source (output valid, output code_unit, output has_unit,
                    output end_of_string, input ready);
    modport sink   (input valid, input code_unit, input has_unit,
                    input end_of_string, output ready);
endinterface

`default_nettype wire

// ----- rtl/u8dec_front.sv -----
// Front end: accepts bytes and tags each one with its lead class.
// Depends on u8dec_pkg and u8dec_byte_if.
`default_nettype none

module u8dec_front (
    u8dec_byte_if.sink          bytes,
    input  u8dec_pkg::q_stat_t  q_stat,
    output logic                push,
    output u8dec_pkg::q_entry_t push_data
);
    import u8dec_pkg::*;

    byte_class_t cls;

    always_comb
    begin
        if ((bytes.in_byte & ASCII_MASK) == 8'h00)
            cls = CLS_ASCII;
        else if ((bytes.in_byte & LEAD2_MASK) == LEAD2_CODE)
            cls = CLS_LEAD2;
        else if ((bytes.in_byte & LEAD3_MASK) == LEAD3_CODE)
            cls = CLS_LEAD3;
        else if ((bytes.in_byte & LEAD4_MASK) == LEAD4_CODE)
            cls = CLS_LEAD4;
        else if ((bytes.in_byte & LEAD5_MASK) == LEAD5_CODE)
            cls = CLS_LEAD5;
        else
            cls = CLS_OTHER;
    end

    assign bytes.ready    = ~q_stat.full;
    assign push           = bytes.valid & ~q_stat.full;
    assign push_data.cls  = cls;
    assign push_data.data = bytes.in_byte;
    assign push_data.last = bytes.last_byte;

endmodule

`default_nettype wire

// ----- rtl/u8dec_queue.sv -----
// Short FIFO of classified bytes between front end and back end.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u8dec_pkg::q_entry_t push_data,
    input  logic                pop,
    output u8dec_pkg::q_entry_t pop_data,
    output u8dec_pkg::q_stat_t  stat
);
    import u8dec_pkg::*;

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = Q_CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = Q_CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/u8dec_back.sv -----
// Back end: sequence state, code unit assembly and the output register.
// Depends on u8dec_pkg and u8dec_unit_if.
`default_nettype none

module u8dec_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8dec_pkg::q_stat_t    q_stat,
    input  u8dec_pkg::q_entry_t   q_data,
    output logic                  pop,
    u8dec_unit_if.source          units,
    output u8dec_pkg::back_stat_t stat
);
    import u8dec_pkg::*;

    logic [1:0]  pend_reg, pend_next;
    logic [11:0] partial_reg, partial_next;
    logic [2:0]  skip_reg, skip_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] unit_reg, unit_next;
    logic        has_reg, has_next;
    logic        eos_reg, eos_next;

    logic        emit;
    logic [15:0] emit_unit;
    logic        emit_has;
    logic        can_load;
    logic [15:0] joined;

    assign can_load = ~out_valid_reg | units.ready;
    assign pop      = ~q_stat.empty & can_load;
    assign joined   = {partial_reg[9:0], q_data.data[5:0]};

    // Per-byte decode step
    always_comb
    begin
        pend_next    = pend_reg;
        partial_next = partial_reg;
        skip_next    = skip_reg;
        emit         = 1'b0;
        emit_unit    = SPACE_UNIT;
        emit_has     = 1'b1;

        if (skip_reg != '0)
        begin
            if (q_data.last)
            begin
                emit      = 1'b1;
                emit_unit = '0;
                emit_has  = 1'b0;
            end
            else
                skip_next = skip_reg - 3'd1;
        end
        else if (pend_reg != '0)
        begin
            if (q_data.last && pend_reg == 2'd2)
                emit = 1'b1;
            else if (pend_reg == 2'd1)
            begin
                emit      = 1'b1;
                emit_unit = joined;
                pend_next = '0;
            end
            else
            begin
                partial_next = {partial_reg[5:0], q_data.data[5:0]};
                pend_next    = 2'd1;
            end
        end
        else
        begin
            unique case (q_data.cls)
                CLS_ASCII:
                begin
                    emit      = 1'b1;
                    emit_unit = {8'h00, q_data.data};
                end
                CLS_LEAD2:
                begin
                    if (q_data.last)
                        emit = 1'b1;
                    else
                    begin
                        partial_next = {4'h0, q_data.data & LEAD2_DATA};
                        pend_next    = 2'd1;
                    end
                end
                CLS_LEAD3:
                begin
                    if (q_data.last)
                        emit = 1'b1;
                    else
                    begin
                        partial_next = {4'h0, q_data.data & LEAD3_DATA};
                        pend_next    = 2'd2;
                    end
                end
                CLS_LEAD4:
                begin
                    emit      = 1'b1;
                    skip_next = SKIP_LEAD4;
                end
                CLS_LEAD5:
                begin
                    emit      = 1'b1;
                    skip_next = SKIP_LEAD5;
                end
                default:
                begin
                    emit      = 1'b1;
                    skip_next = SKIP_OTHER;
                end
            endcase
        end

        // end of string returns everything to the start state
        if (q_data.last)
        begin
            pend_next    = '0;
            partial_next = '0;
            skip_next    = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & ~units.ready;
        unit_next      = unit_reg;
        has_next       = has_reg;
        eos_next       = eos_reg;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
            unit_next      = emit_unit;
            has_next       = emit_has;
            eos_next       = q_data.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            partial_reg   <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pend_reg    <= pend_next;
                partial_reg <= partial_next;
                skip_reg    <= skip_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        has_reg  <= has_next;
        eos_reg  <= eos_next;
    end

    assign units.valid         = out_valid_reg;
    assign units.code_unit     = unit_reg;
    assign units.has_unit      = has_reg;
    assign units.end_of_string = eos_reg;

    assign stat.skip_active = (skip_reg != '0);
    assign stat.pend_active = (pend_reg != '0);

endmodule

`default_nettype wire

// ----- rtl/utf8_to_ucs2_decoder.sv -----
// UTF-8 to UCS-2 decoder, top level.
// An accepted byte is written to the byte queue; the back end then decodes it from the queue
// and loads its result into the output register, from which it is taken.
// Throughput: one byte per cycle unless the output stalls; the back end decodes one queued byte a cycle.
// A stalled output fills the 4-entry byte queue, after which bytes.ready drops.
// Reset (rst_n, async, active low) empties the queue and output register and clears
// the sequence state; no clearing pass, the block takes bytes right after reset.
`default_nettype none

module utf8_to_ucs2_decoder (
    input  logic         clk,
    input  logic         rst_n,
    u8dec_byte_if.sink   bytes,
    u8dec_unit_if.source units
);
    import u8dec_pkg::*;

    // Front end -> queue
    logic       push;
    q_entry_t   push_data;

    // Queue -> back end
    logic       pop;
    q_entry_t   pop_data;
    q_stat_t    q_stat;

    back_stat_t back_stat;

    // Classifies each byte as it is accepted; ready follows queue space only,
    // so a stalled output never reaches the input side combinationally.
    u8dec_front u_front (
        .bytes     (bytes),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    u8dec_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // Holds the multi-byte sequence state and the output register. Bytes that
    // give no item (continuations, dropped bytes) are consumed without a bubble.
    u8dec_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (pop_data),
        .pop    (pop),
        .units  (units),
        .stat   (back_stat)
    );

    // An end marker without a unit carries a zero code unit and the end flag
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        units.valid && !units.has_unit |-> units.end_of_string && units.code_unit == 16'h0000)
        else $error("end marker malformed");

    // Dropping and sequence assembly never overlap
    a_state_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(back_stat.skip_active && back_stat.pend_active))
        else $error("skip and pending both active");

    // A full queue refuses input
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !bytes.ready && !push)
        else $error("byte queue overrun");

    // The back end only draws from a non-empty queue
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("byte queue underrun");

endmodule

`default_nettype wire
